@@ rtl/fdmc_pkg.sv @@
package fdmc_pkg;

    localparam int MAX_WIDTH_DEF   = 320;
    localparam int MAX_HEIGHT_DEF  = 240;
    localparam int FRAME_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_Y      = 3'd5;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_pixel;

    typedef struct packed {
        logic [8:0]  center_x;
        logic [7:0]  center_y;
        logic        motion_found;
        logic [16:0] moving_pixels;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic clear_step;   // one store entry cleared this cycle
        logic pix_step;     // pixel accepted into the pipeline
        logic div_start;    // load the dividers
        logic div_step;     // one quotient bit per divider
        logic res_load;     // capture the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;   // last store entry
        logic frame_end;    // frame-end pixel accepted into the pipeline
        logic pipe_busy;    // pixels still in flight
        logic div_last;     // last quotient bit
    } t_status;

endpackage

@@ rtl/fdmc_ram.sv @@
module fdmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fdmc_ctrl.sv @@
module fdmc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  fdmc_pkg::t_status   i_status,
    output fdmc_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;
    logic       w_accept;

    // the output register frees on a taken result
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_RUN);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.pix_step = w_accept;
                if (i_status.frame_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // frame-end pixel seen; let the pipeline settle
                if (!i_status.pipe_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/fdmc_datapath.sv @@
module fdmc_datapath #(
    parameter int MAX_WIDTH   = fdmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = fdmc_pkg::MAX_HEIGHT_DEF,
    parameter int FRAME_DEPTH = fdmc_pkg::FRAME_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [fdmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fdmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  fdmc_pkg::t_pixel      i_pixel,
    input  fdmc_pkg::t_cmd        i_cmd,
    output fdmc_pkg::t_status     o_status,
    output fdmc_pkg::t_result     o_result
);

    localparam int SLOTS   = FRAME_DEPTH - 1;
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int RW      = $clog2(MAX_HEIGHT + 1);
    localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_SZ = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH   = SLOTS * SLOT_SZ;
    localparam int AW      = $clog2(DEPTH);
    localparam int NW      = $clog2(SLOT_SZ + 1);
    localparam int SXW     = NW + CW;
    localparam int SYW     = NW + RW;
    localparam int QW      = (CW > RW) ? CW : RW;
    localparam int DW      = ((SXW > SYW) ? SXW : SYW) + 2;
    localparam int BCW     = $clog2(QW + 1);

    // configuration registers
    logic [7:0]  r_thr;
    logic [16:0] r_min;
    logic [8:0]  r_fw;
    logic [7:0]  r_fh;
    logic [8:0]  r_defx;
    logic [7:0]  r_defy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 8'd75;
            r_min  <= 17'd100;
            r_fw   <= 9'd320;
            r_fh   <= 8'd240;
            r_defx <= 9'd160;
            r_defy <= 8'd120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fdmc_pkg::REG_DIFF_THRESHOLD: r_thr  <= i_cfg_data[7:0];
                fdmc_pkg::REG_MIN_PIXELS:     r_min  <= i_cfg_data[16:0];
                fdmc_pkg::REG_FRAME_WIDTH:    r_fw   <= i_cfg_data[8:0];
                fdmc_pkg::REG_FRAME_HEIGHT:   r_fh   <= i_cfg_data[7:0];
                fdmc_pkg::REG_DEFAULT_X:      r_defx <= i_cfg_data[8:0];
                fdmc_pkg::REG_DEFAULT_Y:      r_defy <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;
    always_comb begin
        if (r_fw == 9'd0) w_w = CW'(1);
        else if (32'(r_fw) > MAX_WIDTH) w_w = CW'(MAX_WIDTH);
        else w_w = CW'(r_fw);
        if (r_fh == 8'd0) w_h = RW'(1);
        else if (32'(r_fh) > MAX_HEIGHT) w_h = RW'(MAX_HEIGHT);
        else w_h = RW'(r_fh);
    end

    // clearing sweep address
    logic [AW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clear_step) r_clr <= r_clr + AW'(1);
    end
    assign o_status.clear_last = (r_clr == AW'(DEPTH - 1));

    // raster position and slot
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [SW-1:0] r_slot;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_rowbase;
    logic          w_line_end, w_frame_end;
    assign w_line_end  = (32'(r_col) + 1) >= 32'(w_w);
    assign w_frame_end = w_line_end && ((32'(r_row) + 1) >= 32'(w_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_slot <= '0; r_base <= '0; r_rowbase <= '0;
        end else if (i_cmd.pix_step) begin
            if (!w_line_end) begin
                r_col <= r_col + CW'(1);
            end else begin
                r_col <= '0;
                if (!w_frame_end) begin
                    r_row     <= r_row + RW'(1);
                    r_rowbase <= r_rowbase + AW'(MAX_WIDTH);
                end else begin
                    r_row     <= '0;
                    r_rowbase <= '0;
                    if (32'(r_slot) == SLOTS - 1) begin
                        r_slot <= '0; r_base <= '0;
                    end else begin
                        r_slot <= r_slot + SW'(1);
                        r_base <= r_base + AW'(SLOT_SZ);
                    end
                end
            end
        end
    end

    // stage 1: gray products, store read issued
    logic [21:0] r_pr, r_pg, r_pb;
    logic        r_v1;
    logic [AW-1:0] r_a1;
    logic [CW-1:0] r_c1;
    logic [RW-1:0] r_r1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.pix_step;
        end
        r_pr  <= 22'(i_pixel.red_level) * 22'd4899;
        r_pg  <= 22'(i_pixel.green_level) * 22'd9617;
        r_pb  <= 22'(i_pixel.blue_level) * 22'd1868;
        r_a1  <= r_base + r_rowbase + AW'(r_col);
        r_c1  <= r_col;
        r_r1  <= r_row;
    end

    // stage 2: gray, compare, write back
    logic [23:0] w_sum;
    logic [7:0]  w_gray, w_old, w_diff;
    logic        w_move;
    assign w_sum  = 24'(r_pr) + 24'(r_pg) + 24'(r_pb) + 24'd8192;
    assign w_gray = w_sum[21:14];
    assign w_diff = (w_gray > w_old) ? w_gray - w_old : w_old - w_gray;
    assign w_move = w_diff > r_thr;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    assign w_we    = i_cmd.clear_step || r_v1;
    assign w_waddr = i_cmd.clear_step ? r_clr : r_a1;
    assign w_wdata = i_cmd.clear_step ? 8'd0 : w_gray;

    fdmc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_base + r_rowbase + AW'(r_col)),
        .o_rdata (w_old)
    );

    // accumulators
    logic [NW-1:0]  r_cnt;
    logic [SXW-1:0] r_sx;
    logic [SYW-1:0] r_sy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.res_load) begin
            r_cnt <= '0; r_sx <= '0; r_sy <= '0;
        end else if (r_v1 && w_move) begin
            r_cnt <= r_cnt + NW'(1);
            r_sx  <= r_sx + SXW'(r_c1);
            r_sy  <= r_sy + SYW'(r_r1);
        end
    end
    assign o_status.frame_end = i_cmd.pix_step && w_frame_end;
    assign o_status.pipe_busy = r_v1;

    // restoring dividers, (2*sum+cnt)/(2*cnt), one bit a cycle each
    logic [DW-1:0]  r_remx, r_remy, r_den;
    logic [QW-1:0]  r_qx, r_qy;
    logic [BCW-1:0] r_bit;
    logic [DW-1:0]  w_nx, w_ny, w_dsh;
    assign w_dsh = r_den << r_bit;
    assign w_nx  = r_remx - w_dsh;
    assign w_ny  = r_remy - w_dsh;
    assign o_status.div_last = (r_bit == '0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_remx <= (DW'(r_sx) << 1) + DW'(r_cnt);
            r_remy <= (DW'(r_sy) << 1) + DW'(r_cnt);
            r_den  <= DW'(r_cnt) << 1;
            r_qx   <= '0;
            r_qy   <= '0;
            r_bit  <= BCW'(QW - 1);
        end else if (i_cmd.div_step) begin
            if ((r_remx >> r_bit) >= r_den) begin
                r_remx <= w_nx;
                r_qx[r_bit[$clog2(QW)-1:0]] <= 1'b1;
            end
            if ((r_remy >> r_bit) >= r_den) begin
                r_remy <= w_ny;
                r_qy[r_bit[$clog2(QW)-1:0]] <= 1'b1;
            end
            r_bit <= r_bit - BCW'(1);
        end
    end

    // result register
    logic w_found;
    assign w_found = 32'(r_cnt) > 32'(r_min);
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_result.center_x      <= w_found ? 9'(r_qx) : r_defx;
            o_result.center_y      <= w_found ? 8'(r_qy) : r_defy;
            o_result.motion_found  <= w_found;
            o_result.moving_pixels <= 17'(r_cnt);
        end
    end

endmodule

@@ rtl/frame_difference_motion_centroid.sv @@
// Frame-difference motion centroid. Pixels (RGB, raster order) are taken
// one per cycle while a frame is in progress; each is turned to gray, compared
// with the same position FRAME_DEPTH-1 frames back in an on-chip frame store,
// and counted as moving above diff_threshold. After the last pixel of a frame
// the input stalls through pipeline drain, divider load, the quotient bits and
// result load while bit-serial dividers form the rounded centroid, and longer
// while the previous result still waits in the output register; then one
// result is written to the output register. After reset the store is cleared
// one entry a cycle, all (FRAME_DEPTH-1)*MAX_WIDTH*MAX_HEIGHT entries, before
// the first pixel is taken; configuration writes are accepted throughout.
module frame_difference_motion_centroid #(
    parameter int MAX_WIDTH   = fdmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = fdmc_pkg::MAX_HEIGHT_DEF,
    parameter int FRAME_DEPTH = fdmc_pkg::FRAME_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fdmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fdmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fdmc_pkg::t_pixel                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fdmc_pkg::t_result               o_out_data
);

    fdmc_pkg::t_cmd    w_cmd;
    fdmc_pkg::t_status w_status;

    fdmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    fdmc_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_out_data)
    );

endmodule

@@ test/frame_difference_motion_centroid_test.sv @@
module frame_difference_motion_centroid_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW   = fdmc_pkg::MAX_WIDTH_DEF;
    localparam int MAXH   = fdmc_pkg::MAX_HEIGHT_DEF;
    localparam int SLOTS  = fdmc_pkg::FRAME_DEPTH_DEF - 1;
    localparam int PLANE  = MAXW * MAXH;
    localparam int SETTLE = 64;

    // register indexes with no register behind them
    localparam logic [fdmc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [fdmc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [fdmc_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [fdmc_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    fdmc_pkg::t_pixel                    i_in_data;
    logic                                o_out_valid;
    logic                                i_out_ready;
    fdmc_pkg::t_result                   o_out_data;

    frame_difference_motion_centroid DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the block: previous gray frames, raster position, accumulators
    bit [7:0]    gray_history [PLANE*SLOTS];
    int unsigned hist_slot, cur_col, cur_row;
    longint unsigned moving_tally, col_sum, row_sum;
    int unsigned thresh_reg = 75, min_pix_reg = 100, width_reg = 320;
    int unsigned height_reg = 240, dflt_x_reg = 160, dflt_y_reg = 120;

    fdmc_pkg::t_result centroid_queue[$];
    int      error_count = 0;
    int      sender_idle_pct = 0;
    int      sink_stall_pct = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned round_mean(longint unsigned s, longint unsigned n);
        return (2 * s + n) / (2 * n);
    endfunction

    // advance the shadow by one pixel; returns 1 on the last pixel of a frame
    function automatic bit track_pixel(input fdmc_pkg::t_pixel p,
                                       output fdmc_pkg::t_result r);
        int unsigned gray, old_gray, diff, w, h, addr;
        gray = (4899 * int'(p.red_level) + 9617 * int'(p.green_level)
              + 1868 * int'(p.blue_level) + 8192) >> 14;
        w = clamp_dim(width_reg, MAXW);
        h = clamp_dim(height_reg, MAXH);
        addr = hist_slot * PLANE + cur_row * MAXW + cur_col;
        old_gray = gray_history[addr];
        diff = (gray > old_gray) ? gray - old_gray : old_gray - gray;
        gray_history[addr] = gray[7:0];
        if (diff > thresh_reg) begin
            moving_tally++;
            col_sum += cur_col;
            row_sum += cur_row;
        end
        r = '0;
        if (cur_col + 1 < w) begin
            cur_col++;
            return 0;
        end
        cur_col = 0;
        if (cur_row + 1 < h) begin
            cur_row++;
            return 0;
        end
        if (moving_tally > min_pix_reg) begin
            r.center_x = 9'(round_mean(col_sum, moving_tally));
            r.center_y = 8'(round_mean(row_sum, moving_tally));
            r.motion_found = 1'b1;
        end else begin
            r.center_x = 9'(dflt_x_reg);
            r.center_y = 8'(dflt_y_reg);
            r.motion_found = 1'b0;
        end
        r.moving_pixels = 17'(moving_tally);
        cur_row = 0;
        moving_tally = 0;
        col_sum = 0;
        row_sum = 0;
        hist_slot = (hist_slot + 1) % SLOTS;
        return 1;
    endfunction

    // register write, mirrored into the shadow
    task automatic write_reg(input logic [fdmc_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= fdmc_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            fdmc_pkg::REG_DIFF_THRESHOLD: thresh_reg = val & 'hFF;
            fdmc_pkg::REG_MIN_PIXELS:     min_pix_reg = val & 'h1FFFF;
            fdmc_pkg::REG_FRAME_WIDTH:    width_reg = val & 'h1FF;
            fdmc_pkg::REG_FRAME_HEIGHT:   height_reg = val & 'hFF;
            fdmc_pkg::REG_DEFAULT_X:      dflt_x_reg = val & 'h1FF;
            fdmc_pkg::REG_DEFAULT_Y:      dflt_y_reg = val & 'hFF;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input fdmc_pkg::t_pixel p);
        fdmc_pkg::t_result r;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= p;
        do @(posedge i_clk); while (!o_in_ready);
        if (track_pixel(p, r)) centroid_queue.push_back(r);
    endtask

    // drain every pending result and let the pipeline empty out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (centroid_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic fdmc_pkg::t_pixel rand_pixel();
        return fdmc_pkg::t_pixel'(24'($urandom));
    endfunction

    task automatic set_frame(input int unsigned thr, input int unsigned minp,
                             input int unsigned w, input int unsigned h);
        write_reg(fdmc_pkg::REG_DIFF_THRESHOLD, thr);
        write_reg(fdmc_pkg::REG_MIN_PIXELS, minp);
        write_reg(fdmc_pkg::REG_FRAME_WIDTH, w);
        write_reg(fdmc_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // every register plus the unused indexes, which must leave things alone
    task automatic test_register_map();
        wait_idle();
        set_frame(0, 0, 3, 2);
        write_reg(fdmc_pkg::REG_DEFAULT_X, 319);
        write_reg(fdmc_pkg::REG_DEFAULT_Y, 239);
        write_reg(REG_SPARE_A, 'h1FFFF);
        write_reg(REG_SPARE_B, 0);
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
    endtask

    // colour extremes and single channels, then the default point
    task automatic test_gray_extremes();
        wait_idle();
        set_frame(0, 0, 6, 1);
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'h00, 8'h00});
        send_pixel('{8'h00, 8'hFF, 8'h00});
        send_pixel('{8'h00, 8'h00, 8'hFF});
        send_pixel('{8'h80, 8'h7F, 8'h01});
        wait_idle();
        write_reg(fdmc_pkg::REG_MIN_PIXELS, 76800);
        write_reg(fdmc_pkg::REG_DEFAULT_X, 0);
        write_reg(fdmc_pkg::REG_DEFAULT_Y, 0);
        write_reg(fdmc_pkg::REG_DIFF_THRESHOLD, 255);
        for (int i = 0; i < 6; i++) send_pixel('{8'hFF, 8'hFF, 8'hFF});
    endtask

    // out-of-range geometry clamps to the limits
    task automatic test_geometry_clamp();
        wait_idle();
        set_frame(10, 0, 0, 0);
        for (int i = 0; i < 3; i++) send_pixel(rand_pixel());
        wait_idle();
        set_frame(10, 5, 511, 1);
        for (int i = 0; i < MAXW; i++) send_pixel(rand_pixel());
        wait_idle();
        set_frame(10, 5, 1, 255);
        for (int i = 0; i < MAXH; i++) send_pixel(rand_pixel());
    endtask

    // shrink the line and frame while a frame is in progress
    task automatic test_mid_frame_resize();
        wait_idle();
        set_frame(20, 0, 8, 4);
        for (int i = 0; i < 13; i++) send_pixel(rand_pixel());
        wait_idle();
        write_reg(fdmc_pkg::REG_FRAME_WIDTH, 2);
        write_reg(fdmc_pkg::REG_FRAME_HEIGHT, 1);
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
        wait_idle();
        set_frame(20, 0, 4, 3);
    endtask

    // random small frames with random settings and content style
    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int n_pixels);
        int sent, w, h, style;
        sent = 0;
        wait_idle();
        sender_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < n_pixels) begin
            wait_idle();
            w = $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            case ($urandom_range(5))
                0: write_reg(fdmc_pkg::REG_DIFF_THRESHOLD, 0);
                1: write_reg(fdmc_pkg::REG_DIFF_THRESHOLD, 255);
                default: write_reg(fdmc_pkg::REG_DIFF_THRESHOLD, $urandom_range(120));
            endcase
            if ($urandom_range(7) == 0) write_reg(fdmc_pkg::REG_MIN_PIXELS, $urandom);
            else write_reg(fdmc_pkg::REG_MIN_PIXELS, $urandom_range(w * h));
            write_reg(fdmc_pkg::REG_FRAME_WIDTH, w);
            write_reg(fdmc_pkg::REG_FRAME_HEIGHT, h);
            if ($urandom_range(3) == 0) begin
                write_reg(fdmc_pkg::REG_DEFAULT_X, $urandom);
                write_reg(fdmc_pkg::REG_DEFAULT_Y, $urandom);
            end
            style = $urandom_range(3);
            for (int i = 0; i < w * h; i++) begin
                case (style)
                    0: send_pixel('{8'h00, 8'h00, 8'h00});
                    1: send_pixel('{8'hFF, 8'hFF, 8'hFF});
                    default: send_pixel(rand_pixel());
                endcase
            end
            sent += w * h;
        end
    endtask

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        fdmc_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (centroid_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out_data));
            end else begin
                want = centroid_queue.pop_front();
                if (o_out_data.center_x !== want.center_x)
                    report_mismatch($sformatf("center_x got %0d want %0d",
                        o_out_data.center_x, want.center_x));
                if (o_out_data.center_y !== want.center_y)
                    report_mismatch($sformatf("center_y got %0d want %0d",
                        o_out_data.center_y, want.center_y));
                if (o_out_data.motion_found !== want.motion_found)
                    report_mismatch($sformatf("motion_found got %0b want %0b",
                        o_out_data.motion_found, want.motion_found));
                if (o_out_data.moving_pixels !== want.moving_pixels)
                    report_mismatch($sformatf("moving_pixels got %0d want %0d",
                        o_out_data.moving_pixels, want.moving_pixels));
            end
        end
    end

    // overall time limit, allows for the store clearing pass after reset
    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_map();
        test_gray_extremes();
        test_geometry_clamp();
        test_mid_frame_resize();
        test_random_frames(0, 0, 170);
        test_random_frames(81, 0, 170);
        test_random_frames(0, 81, 170);
        test_random_frames(14, 14, 170);
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        wait_idle();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ frame_difference_motion_centroid.f @@
rtl/fdmc_pkg.sv
rtl/fdmc_ram.sv
rtl/fdmc_ctrl.sv
rtl/fdmc_datapath.sv
rtl/frame_difference_motion_centroid.sv
test/frame_difference_motion_centroid_test.sv
